// ----- hdl/binary_to_decimal_ascii_core_defines.svh -----
// Assertion macros used by the checker file of the binary to decimal ASCII core.
// No dependencies.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define B2DA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/b2da_pkg.sv -----
// Types and constants of the binary to decimal ASCII core.
// No dependencies; used by the interfaces, controller, datapath and top level.
package b2da_pkg;

  localparam int VALUE_W    = 64;  // width of the input word field
  localparam int DIGIT_W    = 4;   // one BCD digit
  localparam int CHAR_W     = 6;   // width of the output character field
  localparam int DIGIT_BASE = 10;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = DIGIT_W'(DIGIT_BASE / 2);
  localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = DIGIT_W'((1 << (DIGIT_W - 1)) - DIGIT_BASE / 2);

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture operand, clear BCD register
    logic dabble;  // one double dabble step
    logic dshift;  // drop the top BCD digit
    logic emit;    // write the top digit into the output register
    logic last;    // emitted digit is the final one
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic top_zero;  // top BCD digit is zero
    logic out_free;  // output register can take a digit this cycle
  } sts_t;

endpackage

// ----- hdl/b2da_if.sv -----
// Valid/ready channel interfaces of the binary to decimal ASCII core.
// Depends on b2da_pkg.
interface b2da_in_if;
  logic                         valid;
  logic                         ready;
  logic [b2da_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
  logic                        valid;
  logic                        ready;
  logic [b2da_pkg::CHAR_W-1:0] digit_char;
  logic                        last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ----- hdl/b2da_ctrl.sv -----
// Controller of the binary to decimal ASCII core: conversion and emission sequencer.
// Depends on b2da_pkg.
module b2da_ctrl #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  b2da_pkg::sts_t  sts_i,
  output b2da_pkg::cmd_t  cmd_o
);

  localparam int CNT_MAX = (VALUE_BITS > MAX_DIGITS) ? VALUE_BITS : MAX_DIGITS;
  localparam int CNT_W   = $clog2(CNT_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             started_q, started_d;
  logic             skip;

  assign in_ready_o = (state_q == ST_IDLE);
  // leading zero: drop it unless it is the units digit
  assign skip = sts_i.top_zero && !started_q && (cnt_q != '0);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(VALUE_BITS - 1);
          started_d  = 1'b0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.dabble = 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(MAX_DIGITS - 1);
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (skip) begin
          cmd_o.dshift = 1'b1;
          cnt_d        = cnt_q - CNT_W'(1);
        end else if (sts_i.out_free) begin
          cmd_o.dshift = 1'b1;
          cmd_o.emit   = 1'b1;
          cmd_o.last   = (cnt_q == '0);
          started_d    = 1'b1;
          if (cnt_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
    end
  end

endmodule

// ----- hdl/b2da_dp.sv -----
// Datapath of the binary to decimal ASCII core: operand shifter, BCD register, output register.
// Depends on b2da_pkg.
module b2da_dp #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  b2da_pkg::cmd_t                cmd_i,
  input  logic [b2da_pkg::VALUE_W-1:0]  value_i,
  input  logic                          out_ready_i,
  output b2da_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  output logic [b2da_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                          last_o
);

  localparam int BCD_W = MAX_DIGITS * b2da_pkg::DIGIT_W;

  logic [VALUE_BITS-1:0]         bin_q;
  logic [BCD_W-1:0]              bcd_q;
  logic [BCD_W-1:0]              bcd_adj;
  logic [b2da_pkg::DIGIT_W-1:0]  top_digit;
  logic                          out_valid_q;
  logic [b2da_pkg::CHAR_W-1:0]   char_q;
  logic                          last_q;

  // add-3 correction on every digit of five or more
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= b2da_pkg::DABBLE_LIMIT) begin
        bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
          bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::DABBLE_ADJ;
      end else begin
        bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
          bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
      end
    end
  end

  assign top_digit      = bcd_q[BCD_W-1 -: b2da_pkg::DIGIT_W];
  assign sts_o.top_zero = (top_digit == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= value_i[VALUE_BITS-1:0];
      bcd_q <= '0;
    end else if (cmd_i.dabble) begin
      bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
    end else if (cmd_i.dshift) begin
      bcd_q <= {bcd_q[BCD_W-b2da_pkg::DIGIT_W-1:0], {b2da_pkg::DIGIT_W{1'b0}}};
    end
    if (cmd_i.emit) begin
      char_q <= b2da_pkg::ASCII_ZERO
                + {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}}, top_digit};
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

endmodule

// ----- hdl/binary_to_decimal_ascii_core.sv -----
// Binary to decimal ASCII converter, top level. Takes one unsigned word on in_i and
// sends its decimal digits on out_o as ASCII codes '0'..'9', most significant first,
// leading zeros dropped, last set on the units digit; zero gives a single '0'. Only
// the low VALUE_BITS bits of the word are used, and MAX_DIGITS BCD positions are kept
// (digits beyond them are lost). One word at a time: after acceptance a bit-serial
// double dabble takes one step per operand bit, then the BCD register is scanned one
// digit per cycle over all MAX_DIGITS positions, holding while out_o stalls. in_i is
// ready again as the units digit enters the output register, while that digit waits.
// Depends on b2da_pkg, b2da_if, b2da_ctrl and b2da_dp.
module binary_to_decimal_ascii_core #(
  parameter int VALUE_BITS = 64,  // 8..64
  parameter int MAX_DIGITS = 20   // 3..20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  b2da_in_if.sink    in_i,
  b2da_out_if.source out_o
);

  b2da_pkg::cmd_t cmd;
  b2da_pkg::sts_t sts;

  // sequencer: idle -> convert -> emit
  b2da_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // operand shifter, BCD register and output register
  b2da_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (in_i.value),
    .out_ready_i  (out_o.ready),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .digit_char_o (out_o.digit_char),
    .last_o       (out_o.last)
  );

endmodule

// ----- hdl/b2da_checker.sv -----
// Port-level assertions for binary_to_decimal_ascii_core, with the bind that attaches them.
// Depends on binary_to_decimal_ascii_core_defines.svh and b2da_pkg.
`include "binary_to_decimal_ascii_core_defines.svh"

module b2da_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [b2da_pkg::CHAR_W-1:0] digit_char_i,
  input logic                        last_i
);

  `B2DA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(digit_char_i) && $stable(last_i), "stalled output word changed")
  `B2DA_ASSERT_NOW(a_digit_range, clk_i, rst_ni, out_valid_i, (digit_char_i >= 6'd48) && (digit_char_i <= 6'd57), "output character is not a decimal digit")
  `B2DA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken again while converting")
  `B2DA_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid_i && !last_i, !in_ready_i, "input ready before the number is fully sent")

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .digit_char_i (out_o.digit_char),
  .last_i       (out_o.last)
);
